### hw/rtl/pacvs_pkg.sv
// Package for the phase-aware victim select unit.
// Shared constants, codes and types; no dependencies.
package pacvs_pkg;

    localparam int PC_W      = 64;
    localparam int ADDR_W    = 64;
    localparam int BLK_SHIFT = 6;
    localparam int BLK_W     = ADDR_W - BLK_SHIFT;
    localparam int RADIUS_W  = 8;
    localparam int WIN_W     = 16;
    localparam int WEIGHT_W  = 8;
    localparam int MCNT_W    = 16;
    localparam int SET_IN_W  = 11;
    localparam int WAY_IN_W  = 4;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SPATIAL_RADIUS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_WINDOW   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRONG_WEIGHT  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEAK_WEIGHT    = 8'd3;

    localparam logic [RADIUS_W-1:0] RST_SPATIAL_RADIUS = 8'd2;
    localparam logic [WIN_W-1:0]    RST_PHASE_WINDOW   = 16'd128;
    localparam logic [WEIGHT_W-1:0] RST_STRONG_WEIGHT  = 8'd8;
    localparam logic [WEIGHT_W-1:0] RST_WEAK_WEIGHT    = 8'd2;

    localparam logic [MCNT_W-1:0] MCNT_MAX = 16'hFFFF;

    typedef enum logic {
        OP_QUERY  = 1'b0,
        OP_UPDATE = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_UPD_RD,
        ST_UPD_HIT,
        ST_UPD_WR,
        ST_QRY_RD,
        ST_QRY_RUN,
        ST_QRY_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } score_ctl_t;

endpackage

### hw/rtl/pacvs_score.sv
// Shared way scoring unit: match counts, penalty, score and best-way compare.
// One way enters per cycle; depends on pacvs_pkg.
module pacvs_score
    import pacvs_pkg::*;
#(
    parameter int NUM_WAYS      = 16,
    parameter int HISTORY_DEPTH = 8,
    parameter int STAMP_WIDTH   = 32,
    localparam int WAY_W = $clog2(NUM_WAYS)
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  score_ctl_t                              in_ctl,
    input  logic [WAY_W-1:0]                        in_way,
    input  logic [STAMP_WIDTH-1:0]                  in_stamp,
    input  logic [PC_W-1:0]                         in_pc,
    input  logic [BLK_W-1:0]                        in_blk,
    input  logic [HISTORY_DEPTH-1:0][PC_W-1:0]      ring_pc,
    input  logic [HISTORY_DEPTH-1:0][BLK_W-1:0]     ring_blk,
    input  logic [STAMP_WIDTH-1:0]                  global_stamp,
    input  logic [RADIUS_W-1:0]                     radius,
    input  logic [WEIGHT_W-1:0]                     pc_wt,
    input  logic [WEIGHT_W-1:0]                     sp_weight,
    output logic                                    done,
    output logic [WAY_W-1:0]                        victim
);

    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int PEN_W = $clog2(2 * 255 * HISTORY_DEPTH + 1);
    localparam int SC_W  = ((STAMP_WIDTH > PEN_W) ? STAMP_WIDTH : PEN_W) + 2;

    logic [CNT_W-1:0]       pc_n;
    logic [CNT_W-1:0]       sp_n;
    logic [BLK_W-1:0]       diff;

    score_ctl_t             a_ctl_reg;
    logic [WAY_W-1:0]       a_way_reg;
    logic [STAMP_WIDTH-1:0] a_stamp_reg;
    logic [STAMP_WIDTH-1:0] a_rec_reg;
    logic [CNT_W-1:0]       a_pcn_reg;
    logic [CNT_W-1:0]       a_spn_reg;

    score_ctl_t             b_ctl_reg;
    logic [WAY_W-1:0]       b_way_reg;
    logic [STAMP_WIDTH-1:0] b_stamp_reg;
    logic [STAMP_WIDTH-1:0] b_rec_reg;
    logic [PEN_W-1:0]       b_pen_reg;

    score_ctl_t             c_ctl_reg;
    logic [WAY_W-1:0]       c_way_reg;
    logic [STAMP_WIDTH-1:0] c_stamp_reg;
    logic signed [SC_W-1:0] c_score_reg;

    logic signed [SC_W-1:0] best_score_reg;
    logic [STAMP_WIDTH-1:0] best_stamp_reg;
    logic [WAY_W-1:0]       best_way_reg;
    logic                   done_reg;
    logic                   take;

    always_comb
    begin
        pc_n = '0;
        sp_n = '0;
        diff = '0;
        for (int h = 0; h < HISTORY_DEPTH; h++)
        begin
            diff = (in_blk >= ring_blk[h]) ? (in_blk - ring_blk[h]) : (ring_blk[h] - in_blk);
            if (ring_pc[h] == in_pc)
                pc_n = pc_n + CNT_W'(1);
            if (diff <= BLK_W'(radius))
                sp_n = sp_n + CNT_W'(1);
        end
    end

    always_comb
    begin
        take = c_ctl_reg.first || (c_score_reg > best_score_reg) ||
               ((c_score_reg == best_score_reg) && (c_stamp_reg < best_stamp_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
            c_ctl_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            a_ctl_reg <= in_ctl;
            b_ctl_reg <= a_ctl_reg;
            c_ctl_reg <= b_ctl_reg;
            done_reg  <= c_ctl_reg.valid && c_ctl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        a_way_reg   <= in_way;
        a_stamp_reg <= in_stamp;
        a_rec_reg   <= global_stamp - in_stamp;
        a_pcn_reg   <= pc_n;
        a_spn_reg   <= sp_n;

        b_way_reg   <= a_way_reg;
        b_stamp_reg <= a_stamp_reg;
        b_rec_reg   <= a_rec_reg;
        b_pen_reg   <= PEN_W'(a_pcn_reg) * PEN_W'(pc_wt)
                     + PEN_W'(a_spn_reg) * PEN_W'(sp_weight);

        c_way_reg   <= b_way_reg;
        c_stamp_reg <= b_stamp_reg;
        c_score_reg <= $signed(SC_W'(b_rec_reg)) - $signed(SC_W'(b_pen_reg));

        if (c_ctl_reg.valid && take)
        begin
            best_score_reg <= c_score_reg;
            best_stamp_reg <= c_stamp_reg;
            best_way_reg   <= c_way_reg;
        end
    end

    assign done   = done_reg;
    assign victim = best_way_reg;

endmodule

### hw/rtl/phase_aware_cache_victim_select_unit.sv
// Top level of the phase-aware victim select unit: sequencer, per-way,
// per-set history and per-set phase memories. Depends on pacvs_pkg, pacvs_score.
//
// After reset the unit sweeps its memories, all NUM_SETS*NUM_WAYS way entries,
// and takes no item meanwhile; configuration writes are taken at any time. One
// item is in work at a time: s_tready is high only while the unit is idle. After
// the accept the unit checks the set and way index, with one subtraction per
// cycle for an index out of range (none at the default sizes). An update then
// runs through a set row read with way write, a history match and a write back.
// A query reads the set row, then feeds one way per cycle through the shared
// scoring pipeline, waits for the pipeline to drain and ends in an output cycle;
// the unit returns to idle as its result becomes valid. A result not yet taken
// holds the unit in its output cycle. The way memory read port and the scoring
// unit set the query rate.
module phase_aware_cache_victim_select_unit
    import pacvs_pkg::*;
#(
    parameter int NUM_SETS      = 2048,
    parameter int NUM_WAYS      = 16,
    parameter int HISTORY_DEPTH = 8,
    parameter int STAMP_WIDTH   = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [143:0]         s_tdata,   // set_index, way_index, phys_address, program_counter
    input  logic [0:0]           s_tuser,   // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // victim_way
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W   = $clog2(NUM_WAYS);
    localparam int WADDR_W = $clog2(NUM_SETS * NUM_WAYS);
    localparam int PTR_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int WDEPTH  = NUM_SETS * NUM_WAYS;

    typedef struct packed {
        logic [STAMP_WIDTH-1:0] stamp;
        logic [PC_W-1:0]        pc;
        logic [BLK_W-1:0]       blk;
    } way_ent_t;

    typedef struct packed {
        logic [HISTORY_DEPTH-1:0][PC_W-1:0]  pc;
        logic [HISTORY_DEPTH-1:0][BLK_W-1:0] blk;
    } ring_row_t;

    typedef struct packed {
        logic [PTR_W-1:0]  ptr;
        logic [MCNT_W-1:0] sp_cnt;
        logic [MCNT_W-1:0] pc_cnt;
        logic [WIN_W-1:0]  win_cnt;
        logic              spatial;
    } set_ent_t;

    way_ent_t  way_mem [WDEPTH];
    ring_row_t row_mem [NUM_SETS];
    set_ent_t  set_mem [NUM_SETS];

    way_ent_t  way_rdata;
    ring_row_t row_rdata;
    set_ent_t  set_rdata;

    logic             way_we;
    logic [WADDR_W-1:0] way_waddr;
    way_ent_t         way_wdata;
    logic             way_re;
    logic [WADDR_W-1:0] way_raddr;
    logic             row_we;
    logic [SET_W-1:0] row_waddr;
    ring_row_t        row_wdata;
    set_ent_t         set_wdata;
    logic             row_re;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [SET_IN_W-1:0]  set_reg, set_next;
    logic [WAY_IN_W-1:0]  way_reg, way_next;
    logic [BLK_W-1:0]     blk_reg, blk_next;
    logic [PC_W-1:0]      pc_reg, pc_next;
    logic [STAMP_WIDTH-1:0] gstamp_reg, gstamp_next;
    logic [WAY_W-1:0]     cnt_reg, cnt_next;
    logic [WADDR_W-1:0]   clr_reg, clr_next;
    logic                 sp_hit_reg, sp_hit_next;
    logic                 pc_hit_reg, pc_hit_next;
    logic [WAY_W-1:0]     hold_reg, hold_next;
    logic [WAY_W-1:0]     out_way_reg, out_way_next;
    logic                 m_valid_reg, m_valid_next;
    score_ctl_t           iss_ctl_reg, iss_ctl_next;
    logic [WAY_W-1:0]     iss_way_reg, iss_way_next;

    logic [RADIUS_W-1:0]  radius_reg;
    logic [WIN_W-1:0]     window_reg;
    logic [WEIGHT_W-1:0]  strong_reg;
    logic [WEIGHT_W-1:0]  weak_reg;

    logic [SET_W-1:0]     set_idx;
    logic [WADDR_W-1:0]   way_base;
    logic                 sp_hit_c;
    logic                 pc_hit_c;
    logic [BLK_W-1:0]     hdiff;
    logic [MCNT_W-1:0]    sc_new;
    logic [MCNT_W-1:0]    pcc_new;
    logic [WIN_W-1:0]     wc_new;
    logic [WEIGHT_W-1:0]  pc_w;
    logic [WEIGHT_W-1:0]  sp_w;
    logic                 sc_done;
    logic [WAY_W-1:0]     sc_victim;

    assign set_idx  = SET_W'(set_reg);
    assign way_base = WADDR_W'(set_idx) * WADDR_W'(NUM_WAYS);
    assign pc_w     = set_rdata.spatial ? weak_reg : strong_reg;
    assign sp_w     = set_rdata.spatial ? strong_reg : weak_reg;

    always_ff @(posedge clk)
    begin
        if (way_we)
            way_mem[way_waddr] <= way_wdata;
        if (way_re)
            way_rdata <= way_mem[way_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[row_waddr] <= row_wdata;
        if (row_re)
            row_rdata <= row_mem[set_idx];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
            set_mem[row_waddr] <= set_wdata;
        if (row_re)
            set_rdata <= set_mem[set_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RST_SPATIAL_RADIUS;
            window_reg <= RST_PHASE_WINDOW;
            strong_reg <= RST_STRONG_WEIGHT;
            weak_reg   <= RST_WEAK_WEIGHT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SPATIAL_RADIUS: radius_reg <= cfg_data[RADIUS_W-1:0];
                CFG_PHASE_WINDOW:   window_reg <= cfg_data[WIN_W-1:0];
                CFG_STRONG_WEIGHT:  strong_reg <= cfg_data[WEIGHT_W-1:0];
                CFG_WEAK_WEIGHT:    weak_reg   <= cfg_data[WEIGHT_W-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_comb
    begin
        sp_hit_c = 1'b0;
        pc_hit_c = 1'b0;
        hdiff    = '0;
        for (int h = 0; h < HISTORY_DEPTH; h++)
        begin
            hdiff = (blk_reg >= row_rdata.blk[h]) ? (blk_reg - row_rdata.blk[h])
                                                  : (row_rdata.blk[h] - blk_reg);
            if (hdiff <= BLK_W'(radius_reg))
                sp_hit_c = 1'b1;
            if (row_rdata.pc[h] == pc_reg)
                pc_hit_c = 1'b1;
        end
    end

    always_comb
    begin
        wc_new  = (set_rdata.win_cnt < MCNT_MAX) ? set_rdata.win_cnt + WIN_W'(1)
                                                 : set_rdata.win_cnt;
        sc_new  = (sp_hit_reg && set_rdata.sp_cnt < MCNT_MAX) ? set_rdata.sp_cnt + MCNT_W'(1)
                                                              : set_rdata.sp_cnt;
        pcc_new = (pc_hit_reg && set_rdata.pc_cnt < MCNT_MAX) ? set_rdata.pc_cnt + MCNT_W'(1)
                                                              : set_rdata.pc_cnt;
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        set_next     = set_reg;
        way_next     = way_reg;
        blk_next     = blk_reg;
        pc_next      = pc_reg;
        gstamp_next  = gstamp_reg;
        cnt_next     = cnt_reg;
        clr_next     = clr_reg;
        sp_hit_next  = sp_hit_reg;
        pc_hit_next  = pc_hit_reg;
        hold_next    = hold_reg;
        out_way_next = out_way_reg;
        m_valid_next = m_valid_reg && !m_tready;
        iss_ctl_next = '0;
        iss_way_next = cnt_reg;
        s_tready     = 1'b0;
        way_we       = 1'b0;
        way_waddr    = way_base + WADDR_W'(way_reg);
        way_wdata    = '{stamp: gstamp_reg + STAMP_WIDTH'(1), pc: pc_reg, blk: blk_reg};
        way_re       = 1'b0;
        way_raddr    = way_base + WADDR_W'(cnt_reg);
        row_re       = 1'b0;
        row_we       = 1'b0;
        row_waddr    = set_idx;
        row_wdata    = row_rdata;
        set_wdata    = set_rdata;

        case (state_reg)
            ST_CLEAR:
            begin
                way_we    = 1'b1;
                way_waddr = clr_reg;
                way_wdata = '0;
                row_waddr = SET_W'(clr_reg);
                row_wdata = '0;
                set_wdata = '{ptr: '0, sp_cnt: '0, pc_cnt: '0, win_cnt: '0, spatial: 1'b1};
                row_we    = (clr_reg < WADDR_W'(NUM_SETS));
                clr_next  = clr_reg + WADDR_W'(1);
                if (clr_reg == WADDR_W'(WDEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next    = op_t'(s_tuser[0]);
                    set_next   = s_tdata[10:0];
                    way_next   = s_tdata[14:11];
                    blk_next   = s_tdata[78:15+BLK_SHIFT];
                    pc_next    = s_tdata[142:79];
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if ({6'b0, set_reg} >= 17'(NUM_SETS) || {3'b0, way_reg} >= 7'(NUM_WAYS))
                begin
                    if ({6'b0, set_reg} >= 17'(NUM_SETS))
                        set_next = set_reg - SET_IN_W'(NUM_SETS);
                    if ({3'b0, way_reg} >= 7'(NUM_WAYS))
                        way_next = way_reg - WAY_IN_W'(NUM_WAYS);
                end
                else
                begin
                    state_next = (op_reg == OP_UPDATE) ? ST_UPD_RD : ST_QRY_RD;
                end
            end
            ST_UPD_RD:
            begin
                row_re      = 1'b1;
                way_we      = 1'b1;
                gstamp_next = gstamp_reg + STAMP_WIDTH'(1);
                state_next  = ST_UPD_HIT;
            end
            ST_UPD_HIT:
            begin
                sp_hit_next = sp_hit_c;
                pc_hit_next = pc_hit_c;
                state_next  = ST_UPD_WR;
            end
            ST_UPD_WR:
            begin
                row_we                       = 1'b1;
                row_wdata.pc[set_rdata.ptr]  = pc_reg;
                row_wdata.blk[set_rdata.ptr] = blk_reg;
                set_wdata.ptr = (set_rdata.ptr == PTR_W'(HISTORY_DEPTH - 1)) ? '0
                              : set_rdata.ptr + PTR_W'(1);
                if (wc_new >= window_reg)
                begin
                    set_wdata.spatial = (sc_new >= pcc_new);
                    set_wdata.sp_cnt  = '0;
                    set_wdata.pc_cnt  = '0;
                    set_wdata.win_cnt = '0;
                end
                else
                begin
                    set_wdata.sp_cnt  = sc_new;
                    set_wdata.pc_cnt  = pcc_new;
                    set_wdata.win_cnt = wc_new;
                end
                state_next = ST_IDLE;
            end
            ST_QRY_RD:
            begin
                row_re     = 1'b1;
                cnt_next   = '0;
                state_next = ST_QRY_RUN;
            end
            ST_QRY_RUN:
            begin
                way_re       = 1'b1;
                iss_ctl_next = '{valid: 1'b1, first: (cnt_reg == '0),
                                 last: (cnt_reg == WAY_W'(NUM_WAYS - 1))};
                cnt_next     = cnt_reg + WAY_W'(1);
                if (cnt_reg == WAY_W'(NUM_WAYS - 1))
                    state_next = ST_QRY_WAIT;
            end
            ST_QRY_WAIT:
            begin
                if (sc_done)
                begin
                    hold_next  = sc_victim;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_way_next = hold_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            gstamp_reg  <= '0;
            m_valid_reg <= 1'b0;
            iss_ctl_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            gstamp_reg  <= gstamp_next;
            m_valid_reg <= m_valid_next;
            iss_ctl_reg <= iss_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        set_reg     <= set_next;
        way_reg     <= way_next;
        blk_reg     <= blk_next;
        pc_reg      <= pc_next;
        cnt_reg     <= cnt_next;
        sp_hit_reg  <= sp_hit_next;
        pc_hit_reg  <= pc_hit_next;
        hold_reg    <= hold_next;
        out_way_reg <= out_way_next;
        iss_way_reg <= iss_way_next;
    end

    pacvs_score #(
        .NUM_WAYS      (NUM_WAYS),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .STAMP_WIDTH   (STAMP_WIDTH)
    ) u_score (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ctl       (iss_ctl_reg),
        .in_way       (iss_way_reg),
        .in_stamp     (way_rdata.stamp),
        .in_pc        (way_rdata.pc),
        .in_blk       (way_rdata.blk),
        .ring_pc      (row_rdata.pc),
        .ring_blk     (row_rdata.blk),
        .global_stamp (gstamp_reg),
        .radius       (radius_reg),
        .pc_wt        (pc_w),
        .sp_weight    (sp_w),
        .done         (sc_done),
        .victim       (sc_victim)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = 8'(out_way_reg);

endmodule
